// ===== hw/rtl/flv_tag_timestamp_rebase_top_assert.svh =====
// Assertion macros shared by the timestamp rebase RTL.
`ifndef FLV_TAG_TIMESTAMP_REBASE_TOP_ASSERT_SVH
`define FLV_TAG_TIMESTAMP_REBASE_TOP_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define FTR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ftr assertion failed");

// Condition that must never be seen outside reset.
`define FTR_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("ftr forbidden condition seen");

`endif

// ===== hw/rtl/ftr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ftr_pkg;

    // Input kind codes
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_SOF  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;

    // FLV framing
    localparam logic [3:0] FILE_HDR_LAST = 4'd12;   // 13-byte file header
    localparam int         TAG_HDR_LEN   = 11;
    localparam logic [3:0] TAG_HDR_LAST  = 4'(TAG_HDR_LEN - 1);
    localparam logic [7:0] TAG_SCRIPT    = 8'd18;
    localparam logic [7:0] TAG_AUDIO     = 8'd8;
    localparam logic [7:0] TAG_VIDEO     = 8'd9;
    localparam logic [24:0] PREV_TAG_SIZE_LEN = 25'd4;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_STATUS,
        JOB_HEADER
    } job_kind_t;

    // Single bytes travel in bytes[0]
    typedef struct packed {
        job_kind_t                        kind;
        logic                             status;
        logic [TAG_HDR_LEN-1:0][7:0]      bytes;
    } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ftr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ftr_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // data_byte
    input  wire logic [2:0]    s_axis_tuser,   // kind [1:0], first_file [2]
    input  wire logic          queue_full,
    output logic               job_push,
    output ftr_pkg::job_t      job
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_TAGH,
        PH_PAY,
        PH_DROP,
        PH_IDLE
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [3:0]   count_reg, count_next;
    logic [24:0]  payrem_reg, payrem_next;
    logic [31:0]  offset_reg, offset_next;
    logic [31:0]  last_ts_reg, last_ts_next;
    logic         is_first_reg, is_first_next;
    logic         tag_seen_reg, tag_seen_next;
    logic [7:0]   hdr_reg [ftr_pkg::TAG_HDR_LEN];

    logic         accept;
    logic [1:0]   kind;
    logic [7:0]   in_byte;
    logic [31:0]  new_ts;
    logic [23:0]  data_size;
    logic [24:0]  payrem_dec;
    logic         type_ok;
    logic         eof_bad;

    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = s_axis_tuser[1:0];
    assign in_byte       = s_axis_tdata;

    // Timestamp fields of the buffered header; extended byte holds bits 31..24
    assign new_ts     = {hdr_reg[7], hdr_reg[4], hdr_reg[5], hdr_reg[6]} + offset_reg;
    assign data_size  = {hdr_reg[1], hdr_reg[2], hdr_reg[3]};
    assign payrem_dec = (payrem_reg != 25'd0) ? payrem_reg - 25'd1 : 25'd0;
    assign type_ok    = (hdr_reg[0] == ftr_pkg::TAG_SCRIPT) ||
                        (hdr_reg[0] == ftr_pkg::TAG_AUDIO) ||
                        (hdr_reg[0] == ftr_pkg::TAG_VIDEO);
    assign eof_bad    = (phase_reg == PH_HDR) || (phase_reg == PH_PAY);

    // Classify the item and work out the next state and queued job
    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        payrem_next   = payrem_reg;
        offset_next   = offset_reg;
        last_ts_next  = last_ts_reg;
        is_first_next = is_first_reg;
        tag_seen_next = tag_seen_reg;
        job_push      = 1'b0;
        job.kind      = ftr_pkg::JOB_BYTE;
        job.status    = 1'b0;
        job.bytes     = '0;
        job.bytes[0]  = in_byte;

        if (accept) begin
            priority if (kind == ftr_pkg::KIND_SOF) begin
                is_first_next = s_axis_tuser[2];
                phase_next    = PH_HDR;
                count_next    = 4'd0;
                payrem_next   = 25'd0;
                tag_seen_next = 1'b0;
            end else if (kind == ftr_pkg::KIND_EOF) begin
                if (phase_reg != PH_IDLE) begin
                    if (!eof_bad && tag_seen_reg) begin
                        offset_next = last_ts_reg;
                    end
                    phase_next  = PH_IDLE;
                    count_next  = 4'd0;
                    payrem_next = 25'd0;
                    job_push    = 1'b1;
                    job.kind    = ftr_pkg::JOB_STATUS;
                    job.status  = eof_bad;
                    job.bytes   = '0;
                end
            end else if (kind == ftr_pkg::KIND_DATA) begin
                unique case (phase_reg)
                    PH_HDR: begin
                        if (count_reg == ftr_pkg::FILE_HDR_LAST) begin
                            phase_next = PH_TAGH;
                            count_next = 4'd0;
                        end else begin
                            count_next = count_reg + 4'd1;
                        end
                        job_push = is_first_reg;
                    end
                    PH_TAGH: begin
                        if (count_reg == ftr_pkg::TAG_HDR_LAST) begin
                            count_next = count_reg + 4'd1;
                            if (type_ok) begin
                                for (int k = 0; k < ftr_pkg::TAG_HDR_LEN - 1; k++) begin
                                    job.bytes[k] = hdr_reg[k];
                                end
                                job.bytes[ftr_pkg::TAG_HDR_LEN-1] = in_byte;
                                job.bytes[4] = new_ts[23:16];
                                job.bytes[5] = new_ts[15:8];
                                job.bytes[6] = new_ts[7:0];
                                job.bytes[7] = new_ts[31:24];
                                job.kind      = ftr_pkg::JOB_HEADER;
                                job_push      = 1'b1;
                                last_ts_next  = new_ts;
                                tag_seen_next = 1'b1;
                                payrem_next   = {1'b0, data_size} +
                                                ftr_pkg::PREV_TAG_SIZE_LEN;
                                phase_next    = PH_PAY;
                                count_next    = 4'd0;
                            end else begin
                                phase_next = PH_DROP;
                            end
                        end else begin
                            count_next = count_reg + 4'd1;
                        end
                    end
                    PH_PAY: begin
                        payrem_next = payrem_dec;
                        if (payrem_dec == 25'd0) begin
                            phase_next = PH_TAGH;
                            count_next = 4'd0;
                        end
                        job_push = 1'b1;
                    end
                    default: begin
                        // dropped or between files: ignore
                    end
                endcase
            end else begin
                // unused kind: ignore
            end
        end
    end

    // Phase, counters and offsets
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR;
            count_reg    <= 4'd0;
            payrem_reg   <= 25'd0;
            offset_reg   <= 32'd0;
            last_ts_reg  <= 32'd0;
            is_first_reg <= 1'b0;
            tag_seen_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            payrem_reg   <= payrem_next;
            offset_reg   <= offset_next;
            last_ts_reg  <= last_ts_next;
            is_first_reg <= is_first_next;
            tag_seen_reg <= tag_seen_next;
        end
    end

    // Tag header buffer, filled one byte per transfer
    always_ff @(posedge aclk) begin
        if (accept && kind == ftr_pkg::KIND_DATA && phase_reg == PH_TAGH &&
            count_reg <= ftr_pkg::TAG_HDR_LAST) begin
            hdr_reg[count_reg] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ftr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "flv_tag_timestamp_rebase_top_assert.svh"

module ftr_queue #(
    parameter int DEPTH = ftr_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire ftr_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output ftr_pkg::job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ftr_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `FTR_NEVER(a_no_overflow, aclk, aresetn, push && full)
    `FTR_NEVER(a_no_underflow, aclk, aresetn, pop && !not_empty)

endmodule

`default_nettype wire

// ===== hw/rtl/ftr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "flv_tag_timestamp_rebase_top_assert.svh"

module ftr_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          job_valid,
    input  wire ftr_pkg::job_t head_job,
    output logic               job_pop,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [15:0]        m_axis_tdata,   // out_byte [7:0], status [8], zero fill
    output logic               m_axis_tuser,   // is_status
    output logic               m_axis_tlast    // last
);

    ftr_pkg::job_t  job_reg;
    logic           busy_reg;
    logic [3:0]     idx_reg;
    logic           valid_reg;
    logic [7:0]     byte_reg;
    logic           is_status_reg;
    logic           status_reg;
    logic           last_reg;

    logic           adv;
    logic           fin;
    logic [7:0]     sel_byte;
    logic           sel_is_status;
    logic           sel_status;
    logic           sel_last;

    assign adv     = busy_reg && (!valid_reg || m_axis_tready);
    assign fin     = adv && sel_last;
    assign job_pop = job_valid && (!busy_reg || fin);

    // Pick the result for the current job step
    always_comb begin
        sel_byte      = job_reg.bytes[0];
        sel_is_status = 1'b0;
        sel_status    = 1'b0;
        sel_last      = 1'b1;
        unique case (job_reg.kind)
            ftr_pkg::JOB_BYTE: begin
                sel_byte = job_reg.bytes[0];
            end
            ftr_pkg::JOB_STATUS: begin
                sel_byte      = 8'd0;
                sel_is_status = 1'b1;
                sel_status    = job_reg.status;
            end
            ftr_pkg::JOB_HEADER: begin
                sel_byte = job_reg.bytes[idx_reg];
                sel_last = (idx_reg == ftr_pkg::TAG_HDR_LAST);
            end
            default: begin
                sel_byte = 8'd0;
            end
        endcase
    end

    // Job holder and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            if (job_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= 4'd0;
            end else if (fin) begin
                busy_reg <= 1'b0;
            end else if (adv) begin
                idx_reg <= idx_reg + 4'd1;
            end

            if (adv) begin
                valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= head_job;
        end
        if (adv) begin
            byte_reg      <= sel_byte;
            is_status_reg <= sel_is_status;
            status_reg    <= sel_status;
            last_reg      <= sel_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'd0, status_reg, byte_reg};
    assign m_axis_tuser  = is_status_reg;
    assign m_axis_tlast  = last_reg;

    `FTR_ASSERT(a_hdr_idx_range, aclk, aresetn,
        busy_reg && job_reg.kind == ftr_pkg::JOB_HEADER |-> idx_reg <= ftr_pkg::TAG_HDR_LAST)
    `FTR_ASSERT(a_burst_steps, aclk, aresetn,
        adv && !sel_last |=> busy_reg && idx_reg == $past(idx_reg) + 4'd1)
    `FTR_ASSERT(a_status_zero_byte, aclk, aresetn,
        valid_reg && is_status_reg |-> byte_reg == 8'd0 && last_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/flv_tag_timestamp_rebase_top.sv =====
// FLV merge stage: rewrites tag timestamps so that files play back to back.
// Input channel (s_axis_*): one item per transfer; tuser[1:0] is the kind
// (data byte, start of file, end of file), tuser[2] flags the first file at
// start of file, tdata carries the stream byte.
// Output channel (m_axis_*): merged stream bytes, and one status result per
// end of file (tuser high, tdata[8] set when the file was truncated); tlast
// marks the last result caused by an input item.
// A result passes from its input transfer through the job queue, the job
// register and the output register. Throughput: one input item per cycle
// while the job queue has room; a rewritten tag header leaves as 11 output
// transfers, one per cycle from the single output register unless stalled.
// Reset: the block sits in the file header phase of a non-first file with a
// zero timestamp offset; the queue and output register are emptied.
// When the receiver stalls, results wait in the output register and job
// queue; s_axis_tready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module flv_tag_timestamp_rebase_top #(
    parameter int QUEUE_DEPTH = ftr_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // data_byte
    input  wire logic [2:0]    s_axis_tuser,   // kind [1:0], first_file [2]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [15:0]        m_axis_tdata,   // out_byte [7:0], status [8], zero fill
    output logic               m_axis_tuser,   // is_status
    output logic               m_axis_tlast    // last
);

    ftr_pkg::job_t  push_job;
    ftr_pkg::job_t  head_job;
    logic           job_push;
    logic           queue_full;
    logic           job_pop;
    logic           job_valid;

    ftr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .job_push      (job_push),
        .job           (push_job)
    );

    ftr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .head_job  (head_job)
    );

    ftr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (job_valid),
        .head_job      (head_job),
        .job_pop       (job_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
